// ----- src/e2rm_pkg.sv -----
package e2rm_pkg;

    localparam int CordicSteps = 30;
    localparam int CordicFrac  = 30;
    localparam logic signed [33:0] CordicStart = 34'sd652032874;

    localparam logic [2:0] FUNC_XYZ = 3'd0;
    localparam logic [2:0] FUNC_YXZ = 3'd1;
    localparam logic [2:0] FUNC_ZXY = 3'd2;
    localparam logic [2:0] FUNC_ZYX = 3'd3;
    localparam logic [2:0] FUNC_YZX = 3'd4;
    localparam logic [2:0] FUNC_XZY = 3'd5;

    // atan(2^-i) in units of 2^-32 turn
    function automatic logic [31:0] atan_lut(input int i);
        logic [31:0] v;
        case (i)
            0:  v = 32'h20000000;  1: v = 32'h12E4051E;  2: v = 32'h09FB385B;
            3:  v = 32'h051111D4;  4: v = 32'h028B0D43;  5: v = 32'h0145D7E1;
            6:  v = 32'h00A2F61E;  7: v = 32'h00517C55;  8: v = 32'h0028BE53;
            9:  v = 32'h00145F2F; 10: v = 32'h000A2F98; 11: v = 32'h000517CC;
            12: v = 32'h00028BE6; 13: v = 32'h000145F3; 14: v = 32'h0000A2FA;
            15: v = 32'h0000517D; 16: v = 32'h000028BE; 17: v = 32'h0000145F;
            18: v = 32'h00000A30; 19: v = 32'h00000518; 20: v = 32'h0000028C;
            21: v = 32'h00000146; 22: v = 32'h000000A3; 23: v = 32'h00000051;
            24: v = 32'h00000029; 25: v = 32'h00000014; 26: v = 32'h0000000A;
            27: v = 32'h00000005; 28: v = 32'h00000003; 29: v = 32'h00000001;
            default: v = 32'h0;
        endcase
        return v;
    endfunction

endpackage

// ----- src/e2rm_sincos.sv -----
// Pipelined CORDIC: one micro-rotation per stage, then rounding and clamp.
module e2rm_sincos #(
    parameter int ANGLE_BITS     = 16,
    parameter int COEF_FRAC_BITS = 14
) (
    input  logic                              i_clk,
    input  logic [ANGLE_BITS-1:0]             i_angle,
    output logic signed [COEF_FRAC_BITS+1:0]  o_cos,
    output logic signed [COEF_FRAC_BITS+1:0]  o_sin
);
    localparam int N  = e2rm_pkg::CordicSteps;
    localparam int CW = COEF_FRAC_BITS + 2;
    localparam int SH = e2rm_pkg::CordicFrac - COEF_FRAC_BITS;

    logic signed [33:0] r_x [N+1];
    logic signed [33:0] r_y [N+1];
    logic signed [33:0] r_z [N+1];
    logic               r_flip [N+1];
    logic signed [CW-1:0] r_cos, r_sin;

    logic [31:0] t_in, t_rot;
    logic        flip_in;

    assign t_in    = {i_angle, {(32-ANGLE_BITS){1'b0}}};
    assign flip_in = t_in[31] ^ t_in[30];
    assign t_rot   = flip_in ? t_in + 32'h80000000 : t_in;

    always_ff @(posedge i_clk) begin
        r_x[0]    <= e2rm_pkg::CordicStart;
        r_y[0]    <= '0;
        r_z[0]    <= {{2{t_rot[31]}}, t_rot};
        r_flip[0] <= flip_in;
    end

    for (genvar i = 0; i < N; i++) begin : g_stage
        logic signed [33:0] atn;
        assign atn = {2'b00, e2rm_pkg::atan_lut(i)};
        always_ff @(posedge i_clk) begin
            if (!r_z[i][33]) begin
                r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                r_z[i+1] <= r_z[i] - atn;
            end else begin
                r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                r_z[i+1] <= r_z[i] + atn;
            end
            r_flip[i+1] <= r_flip[i];
        end
    end

    function automatic logic signed [CW-1:0] rnd_sat(input logic signed [33:0] v);
        logic signed [34:0] t;
        logic signed [34:0] one;
        t   = ($signed({v[33], v}) + (35'sd1 <<< (SH-1))) >>> SH;
        one = 35'sd1 <<< COEF_FRAC_BITS;
        if (t > one)       t = one;
        else if (t < -one) t = -one;
        return t[CW-1:0];
    endfunction

    logic signed [33:0] fx, fy;
    assign fx = r_flip[N] ? -r_x[N] : r_x[N];
    assign fy = r_flip[N] ? -r_y[N] : r_y[N];

    always_ff @(posedge i_clk) begin
        r_cos <= rnd_sat(fx);
        r_sin <= rnd_sat(fy);
    end

    assign o_cos = r_cos;
    assign o_sin = r_sin;
endmodule

// ----- src/e2rm_matrix.sv -----
// Products and sums in two registered levels, then saturate.
module e2rm_matrix #(
    parameter int COEF_FRAC_BITS = 14
) (
    input  logic                             i_clk,
    input  logic [2:0]                       i_func,
    input  logic signed [COEF_FRAC_BITS+1:0] i_a, i_b, i_c, i_d, i_e, i_f,
    output logic signed [COEF_FRAC_BITS+1:0] o_m [9]
);
    localparam int CW = COEF_FRAC_BITS + 2;
    localparam int PW = 2 * CW;

    function automatic logic signed [CW:0] mul(input logic signed [CW:0] p,
                                               input logic signed [CW:0] q);
        logic signed [2*CW+1:0] t;
        t = (p * q + ((2*CW+2)'(1) <<< (COEF_FRAC_BITS-1))) >>> COEF_FRAC_BITS;
        return t[CW:0];
    endfunction

    // level 1: first products and passed-through factors
    logic signed [CW:0] r_p, r_q, r_r, r_s, r_u0, r_u1, r_u2, r_u3, r_u4, r_u5;
    logic signed [CW:0] r_ka, r_kb, r_kd, r_ke, r_kf;
    logic [2:0]         r_fn1;
    logic signed [CW:0] a, b, c, d, e, f;

    assign a = (CW+1)'(i_a); assign b = (CW+1)'(i_b); assign c = (CW+1)'(i_c);
    assign d = (CW+1)'(i_d); assign e = (CW+1)'(i_e); assign f = (CW+1)'(i_f);

    logic signed [CW:0] n_p, n_q, n_r, n_s;
    always_comb begin
        case (i_func)
            e2rm_pkg::FUNC_XYZ, e2rm_pkg::FUNC_ZYX: begin
                n_p = mul(a, e); n_q = mul(a, f); n_r = mul(b, e); n_s = mul(b, f);
            end
            e2rm_pkg::FUNC_YXZ, e2rm_pkg::FUNC_ZXY: begin
                n_p = mul(c, e); n_q = mul(c, f); n_r = mul(d, e); n_s = mul(d, f);
            end
            default: begin
                n_p = mul(a, c); n_q = mul(a, d); n_r = mul(b, c); n_s = mul(b, d);
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_p <= n_p; r_q <= n_q; r_r <= n_r; r_s <= n_s;
        r_u0 <= mul(c, e); r_u1 <= mul(c, f); r_u2 <= mul(b, c);
        r_u3 <= mul(a, c); r_u4 <= mul(a, f); r_u5 <= mul(a, e);
        r_ka <= a; r_kb <= b; r_kd <= d; r_ke <= e; r_kf <= f;
        r_fn1 <= i_func;
    end

    // level 2: combine; sums stay within +-2^(F+1), so CW+1 bits suffice
    logic signed [CW:0] n_m [9];
    logic signed [CW:0] kb, kd, ke, kf, ka;
    assign ka = r_ka; assign kb = r_kb; assign kd = r_kd;
    assign ke = r_ke; assign kf = r_kf;

    always_comb begin
        for (int k = 0; k < 9; k++) n_m[k] = '0;
        case (r_fn1)
            e2rm_pkg::FUNC_XYZ: begin
                n_m[0] = r_u0; n_m[1] = -r_u1; n_m[2] = kd;
                n_m[3] = r_q + mul(r_r, kd); n_m[4] = r_p - mul(r_s, kd);
                n_m[5] = -r_u2;
                n_m[6] = r_s - mul(r_p, kd); n_m[7] = r_r + mul(r_q, kd);
                n_m[8] = r_u3;
            end
            e2rm_pkg::FUNC_YXZ: begin
                n_m[0] = r_p + mul(r_s, kb); n_m[1] = mul(r_r, kb) - r_q;
                n_m[2] = mul(ka, kd);
                n_m[3] = r_u4; n_m[4] = r_u5; n_m[5] = -kb;
                n_m[6] = mul(r_q, kb) - r_r; n_m[7] = r_s + mul(r_p, kb);
                n_m[8] = r_u3;
            end
            e2rm_pkg::FUNC_ZXY: begin
                n_m[0] = r_p - mul(r_s, kb); n_m[1] = -r_u4;
                n_m[2] = r_r + mul(r_q, kb);
                n_m[3] = r_q + mul(r_r, kb); n_m[4] = r_u5;
                n_m[5] = r_s - mul(r_p, kb);
                n_m[6] = -mul(ka, kd); n_m[7] = kb; n_m[8] = r_u3;
            end
            e2rm_pkg::FUNC_ZYX: begin
                n_m[0] = r_u0; n_m[1] = mul(r_r, kd) - r_q;
                n_m[2] = mul(r_p, kd) + r_s;
                n_m[3] = r_u1; n_m[4] = mul(r_s, kd) + r_p;
                n_m[5] = mul(r_q, kd) - r_r;
                n_m[6] = -kd; n_m[7] = r_u2; n_m[8] = r_u3;
            end
            e2rm_pkg::FUNC_YZX: begin
                n_m[0] = r_u0; n_m[1] = r_s - mul(r_p, kf);
                n_m[2] = mul(r_r, kf) + r_q;
                n_m[3] = kf; n_m[4] = r_u5; n_m[5] = -mul(kb, ke);
                n_m[6] = -mul(kd, ke); n_m[7] = mul(r_q, kf) + r_r;
                n_m[8] = r_p - mul(r_s, kf);
            end
            e2rm_pkg::FUNC_XZY: begin
                n_m[0] = r_u0; n_m[1] = -kf; n_m[2] = mul(kd, ke);
                n_m[3] = mul(r_p, kf) + r_s; n_m[4] = r_u5;
                n_m[5] = mul(r_q, kf) - r_r;
                n_m[6] = mul(r_r, kf) - r_q; n_m[7] = mul(kb, ke);
                n_m[8] = mul(r_s, kf) + r_p;
            end
            default: begin
                n_m[0] = (CW+1)'(1) <<< COEF_FRAC_BITS;
                n_m[4] = (CW+1)'(1) <<< COEF_FRAC_BITS;
                n_m[8] = (CW+1)'(1) <<< COEF_FRAC_BITS;
            end
        endcase
    end

    logic signed [CW:0] r_m [9];
    always_ff @(posedge i_clk) begin
        r_m <= n_m;
    end

    localparam logic signed [CW:0] One    = (CW+1)'(1) <<< COEF_FRAC_BITS;
    localparam logic signed [CW:0] NegOne = -One;
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 9; k++) begin
            if (r_m[k] > One)          o_m[k] <= One[CW-1:0];
            else if (r_m[k] < NegOne)  o_m[k] <= NegOne[CW-1:0];
            else                       o_m[k] <= r_m[k][CW-1:0];
        end
    end
endmodule

// ----- src/euler_to_rotation_matrix.sv -----
// Euler angles to 3x3 rotation matrix, signed Q1.COEF_FRAC_BITS entries.
// Channels: raise start with three binary angles and an order code
// (0 XYZ, 1 YXZ, 2 ZXY, 3 ZYX, 4 YZX, 5 XZY; 6 and 7 give identity).
// busy is always low: one transaction is taken every cycle.
// Results come out with o_valid high for exactly one cycle, in order.
// Pipeline: the 30-step CORDIC (input register, 30 rotations, rounding)
// followed by the product, sum and saturate stages; the valid pipe is
// delayed to match.
// Throughput: one item per cycle, set by the fully unrolled CORDIC.
// Reset clears the valid pipe only; data in flight is dropped.
// The receiver cannot stall, so nothing is held back.
module euler_to_rotation_matrix #(
    parameter int ANGLE_BITS     = 16,
    parameter int COEF_FRAC_BITS = 14
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [ANGLE_BITS-1:0]            i_angle_x,
    input  logic [ANGLE_BITS-1:0]            i_angle_y,
    input  logic [ANGLE_BITS-1:0]            i_angle_z,
    input  logic [2:0]                       i_func,
    output logic                             o_valid,
    output logic signed [COEF_FRAC_BITS+1:0] o_m00, o_m01, o_m02,
    output logic signed [COEF_FRAC_BITS+1:0] o_m10, o_m11, o_m12,
    output logic signed [COEF_FRAC_BITS+1:0] o_m20, o_m21, o_m22
);
    localparam int SC_LAT = e2rm_pkg::CordicSteps + 2;
    localparam int LAT    = SC_LAT + 3;
    localparam int CW     = COEF_FRAC_BITS + 2;

    logic signed [CW-1:0] a, b, c, d, e, f;
    logic signed [CW-1:0] m [9];
    logic [LAT-1:0]       r_vld;
    logic [2:0]           r_fn [SC_LAT];

    assign busy = 1'b0;

    e2rm_sincos #(.ANGLE_BITS(ANGLE_BITS), .COEF_FRAC_BITS(COEF_FRAC_BITS)) u_sx (
        .i_clk(i_clk), .i_angle(i_angle_x), .o_cos(a), .o_sin(b));
    e2rm_sincos #(.ANGLE_BITS(ANGLE_BITS), .COEF_FRAC_BITS(COEF_FRAC_BITS)) u_sy (
        .i_clk(i_clk), .i_angle(i_angle_y), .o_cos(c), .o_sin(d));
    e2rm_sincos #(.ANGLE_BITS(ANGLE_BITS), .COEF_FRAC_BITS(COEF_FRAC_BITS)) u_sz (
        .i_clk(i_clk), .i_angle(i_angle_z), .o_cos(e), .o_sin(f));

    always_ff @(posedge i_clk) begin
        r_fn[0] <= i_func;
        for (int k = 1; k < SC_LAT; k++) r_fn[k] <= r_fn[k-1];
    end

    e2rm_matrix #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_mat (
        .i_clk(i_clk), .i_func(r_fn[SC_LAT-1]),
        .i_a(a), .i_b(b), .i_c(c), .i_d(d), .i_e(e), .i_f(f), .o_m(m));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[LAT-2:0], start};
        end
    end

    assign o_valid = r_vld[LAT-1];
    assign o_m00 = m[0]; assign o_m01 = m[1]; assign o_m02 = m[2];
    assign o_m10 = m[3]; assign o_m11 = m[4]; assign o_m12 = m[5];
    assign o_m20 = m[6]; assign o_m21 = m[7]; assign o_m22 = m[8];
endmodule
